// ----- design/ptd_pkg.sv -----
// Shared types, codes and reset constants of the periodic task dispatcher.
package ptd_pkg;

   localparam int unsigned PTD_MAX_SLOTS  = 8;
   localparam int unsigned PTD_SLOTS_DEF  = 8;
   localparam int unsigned PERIOD_W       = 16;
   localparam int unsigned SEQ_W          = 32;
   localparam int unsigned CSR_DATA_W     = 64;
   localparam int unsigned SLOT_IDX_W     = 3;

   localparam logic [CSR_DATA_W-1:0] RESET_PERIODS_LO = 64'd1407396358717445;
   localparam logic [CSR_DATA_W-1:0] RESET_PERIODS_HI = 64'd281477124194959380;
   localparam logic [PTD_MAX_SLOTS-1:0] RESET_PROFILE_MASK = 8'h0F;
   localparam logic [PTD_MAX_SLOTS-1:0] RESET_GATE_MASK    = 8'h02;

   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   typedef enum logic [1:0] {
      CSR_PERIODS_LO = 2'd0,
      CSR_PERIODS_HI = 2'd1,
      CSR_PROFILE    = 2'd2,
      CSR_GATE       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_RUN  = 2'd0,
      ACT_SKIP = 2'd1,
      ACT_IDLE = 2'd2
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0]    periods_lo;
      logic [CSR_DATA_W-1:0]    periods_hi;
      logic [PTD_MAX_SLOTS-1:0] profile_mask;
      logic [PTD_MAX_SLOTS-1:0] gate_mask;
   } cfg_type;

   typedef struct packed {
      logic tick;   // advance the counters of slots not already due
      logic open;   // begin a dispatch pass, capture the sample sequence
      logic step;   // examine one slot of the pass
   } cmd_type;

   typedef struct packed {
      logic any_due;    // at least one slot due
      logic scan_last;  // no due slot above the current scan position
   } status_type;

endpackage

// ----- design/periodic_task_dispatcher_unit.sv -----
// Top level of the periodic task dispatcher: registers, controller and datapath.
// A tick request gives no result; busy stays low.
// A dispatch pass with nothing due gives its idle result in the cycle after the request.
// Otherwise the scan visits one slot per cycle from slot 0 up to the highest due slot,
// holding busy while it scans; each result is registered and appears in the cycle after its slot.
// Synchronous active-high reset restores the register defaults and clears counters and flags.
module periodic_task_dispatcher_unit import ptd_pkg::*; #(
   parameter int unsigned SLOT_COUNT = PTD_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [SEQ_W-1:0]      req_sample_seq,
   // result channel, one strobe per result, cannot be stalled
   output logic                  rsp_valid,
   output logic [SLOT_IDX_W-1:0] rsp_slot_index,
   output logic [1:0]            rsp_action,
   output logic                  rsp_profiled,
   output logic                  rsp_last,
   // configuration write port
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Hold periods and masks; write them only while no request is in flight.
   ptd_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Decide between tick, idle reply and scan; advance the scan until the last due slot.
   ptd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Count ticks per slot, drop due flags as the scan passes, apply the sample gate.
   ptd_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg),
      .req_sample_seq (req_sample_seq),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_slot_index (rsp_slot_index),
      .rsp_action     (rsp_action),
      .rsp_profiled   (rsp_profiled),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- design/ptd_regs.sv -----
// Configuration register file of the periodic task dispatcher.
module ptd_regs import ptd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PERIODS_LO: cfg_in.periods_lo   = csr_wdata;
            CSR_PERIODS_HI: cfg_in.periods_hi   = csr_wdata;
            CSR_PROFILE:    cfg_in.profile_mask = csr_wdata[PTD_MAX_SLOTS-1:0];
            CSR_GATE:       cfg_in.gate_mask    = csr_wdata[PTD_MAX_SLOTS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.periods_lo   <= RESET_PERIODS_LO;
         cfg_ff.periods_hi   <= RESET_PERIODS_HI;
         cfg_ff.profile_mask <= RESET_PROFILE_MASK;
         cfg_ff.gate_mask    <= RESET_GATE_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/ptd_ctrl.sv -----
// Controller state machine: sequences ticks and dispatch scans.
module ptd_ctrl import ptd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_op,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_op == OP_DISPATCH) && status.any_due) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.tick = start && (req_op == OP_TICK);
            cmd.open = start && (req_op == OP_DISPATCH);
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            busy     = 1'b1;
         end
         default: begin
            cmd  = '0;
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/ptd_datapath.sv -----
// Datapath: slot counters, due flags, gate sequence and result register.
module ptd_datapath import ptd_pkg::*; #(
   parameter int unsigned SLOT_COUNT = PTD_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  cfg_type               cfg,
   input  logic [SEQ_W-1:0]      req_sample_seq,
   output status_type            status,
   output logic                  rsp_valid,
   output logic [SLOT_IDX_W-1:0] rsp_slot_index,
   output logic [1:0]            rsp_action,
   output logic                  rsp_profiled,
   output logic                  rsp_last
);

   logic [2*CSR_DATA_W-1:0]   periods_all;
   logic [PTD_MAX_SLOTS-1:0]  due_ff, due_in;
   logic [PTD_MAX_SLOTS-1:0]  higher_due;
   logic [SLOT_IDX_W-1:0]     idx_ff, idx_in;
   logic [SEQ_W-1:0]          seq_ff, seq_in;
   logic [SEQ_W-1:0]          consumed_ff, consumed_in;
   logic                      cur_due, gated, seq_match, skip;

   logic                      valid_ff, valid_in;
   logic [SLOT_IDX_W-1:0]     slot_ff, slot_in;
   action_type                action_ff, action_in;
   logic                      prof_ff, prof_in;
   logic                      last_ff, last_in;

   assign periods_all = {cfg.periods_hi, cfg.periods_lo};

   for (genvar s = 0; s < PTD_MAX_SLOTS; s++) begin : g_slot
      if (s < SLOT_COUNT) begin : g_active
         logic [PERIOD_W-1:0] period;
         logic [PERIOD_W-1:0] count_ff, count_in, count_inc;
         logic                due_s;

         assign period    = periods_all[PERIOD_W*s +: PERIOD_W];
         assign count_inc = count_ff + 16'd1;

         always_comb begin
            count_in = count_ff;
            due_s    = due_ff[s];
            if (cmd.tick && !due_ff[s]) begin
               if (count_inc >= period) begin
                  count_in = '0;
                  due_s    = 1'b1;
               end else begin
                  count_in = count_inc;
               end
            end else if (cmd.step && (idx_ff == SLOT_IDX_W'(s))) begin
               due_s = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               count_ff <= '0;
            end else begin
               count_ff <= count_in;
            end
         end

         assign due_in[s] = due_s;
      end else begin : g_absent
         assign due_in[s] = 1'b0;
      end
   end

   // due slots strictly above the scan position
   always_comb begin
      for (int i = 0; i < PTD_MAX_SLOTS; i++) begin
         higher_due[i] = due_ff[i] && (SLOT_IDX_W'(i) > idx_ff);
      end
   end

   assign status.any_due   = |due_ff;
   assign status.scan_last = ~|higher_due;

   assign cur_due   = due_ff[idx_ff];
   assign gated     = cfg.gate_mask[idx_ff];
   assign seq_match = (seq_ff == consumed_ff);
   assign skip      = gated && seq_match;

   always_comb begin
      seq_in      = cmd.open ? req_sample_seq : seq_ff;
      idx_in      = idx_ff;
      consumed_in = consumed_ff;
      if (cmd.open) begin
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + 3'd1;
      end
      if (cmd.step && cur_due && gated && !seq_match) begin
         consumed_in = seq_ff;
      end
   end

   always_comb begin
      valid_in  = (cmd.open && !status.any_due) || (cmd.step && cur_due);
      slot_in   = idx_ff;
      action_in = skip ? ACT_SKIP : ACT_RUN;
      prof_in   = !skip && cfg.profile_mask[idx_ff];
      last_in   = status.scan_last;
      if (cmd.open) begin
         slot_in   = '0;
         action_in = ACT_IDLE;
         prof_in   = 1'b0;
         last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         due_ff      <= '0;
         idx_ff      <= '0;
         consumed_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         due_ff      <= due_in;
         idx_ff      <= idx_in;
         consumed_ff <= consumed_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff    <= seq_in;
      slot_ff   <= slot_in;
      action_ff <= action_in;
      prof_ff   <= prof_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_action     = action_ff;
   assign rsp_profiled   = prof_ff;
   assign rsp_last       = last_ff;

endmodule

// ----- design/ptd_checker.sv -----
// Port-level checker of the periodic task dispatcher and its bind.
module ptd_checker import ptd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  req_op,
   input logic                  rsp_valid,
   input logic [SLOT_IDX_W-1:0] rsp_slot_index,
   input logic [1:0]            rsp_action,
   input logic                  rsp_profiled,
   input logic                  rsp_last
);

   // a tick request never yields a result
   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_TICK)) |=> !rsp_valid)
      else $error("result after tick request");

   // the pass stays busy exactly until its final result
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (busy == !rsp_last))
      else $error("busy disagrees with last flag");

   a_idle_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_IDLE)) |->
         (rsp_last && (rsp_slot_index == '0) && !rsp_profiled))
      else $error("malformed idle result");

   a_skip_unprofiled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_SKIP)) |-> !rsp_profiled)
      else $error("skipped result marked profiled");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_action == ACT_RUN) || (rsp_action == ACT_SKIP) ||
                     (rsp_action == ACT_IDLE)))
      else $error("undefined action code");

endmodule

bind periodic_task_dispatcher_unit ptd_checker u_ptd_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_op         (req_op),
   .rsp_valid      (rsp_valid),
   .rsp_slot_index (rsp_slot_index),
   .rsp_action     (rsp_action),
   .rsp_profiled   (rsp_profiled),
   .rsp_last       (rsp_last)
);
